>>> hw/rtl/twdd_pkg.sv
// ============================================================================
// twdd_pkg: shared types and constants of the tail-delimited word deframer
// Beat formats for the byte input and the frame report output, the tail
// pattern and the size of the frame head store.
// ============================================================================
package twdd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } in_beat_t;

    typedef struct packed {
        logic        frame_status;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_bits;
        logic [15:0] word_count;
    } out_beat_t;

    typedef enum logic {
        FRAME_OK    = 1'b0,
        FRAME_SHORT = 1'b1
    } frame_status_t;

    localparam int unsigned HEAD_DEPTH = 11;
    localparam int unsigned HEAD_IDX_W = 4;
    localparam int unsigned TAIL_LEN   = 4;
    localparam int unsigned KEEP_BYTES = 3;
    localparam int unsigned WORD_SAT   = 65535;
    localparam int unsigned MIN_WORDS  = 2;

    localparam logic [23:0] TAIL_LEAD = 24'h00_0080;
    localparam logic [7:0]  TAIL_LAST = 8'h7F;

endpackage

>>> hw/rtl/tail_delimited_word_deframer_core.sv
// ============================================================================
// tail_delimited_word_deframer_core: byte stream to frame report deframer
// Finds frames ended by the tail 00 00 80 7F and reports the first two
// aligned little-endian words, the word count and a too-short status.
//
//   channel | dir | handshake          | beat
//   s_      | in  | s_valid / s_ready  | twdd_pkg::in_beat_t  (rx_byte, chunk_end)
//   m_      | out | m_valid / m_ready  | twdd_pkg::out_beat_t (status, pitch, yaw, count)
//
// A byte beat is taken every cycle unless a stalled report blocks input; the
// report for the beat completing the tail passes from the input register to
// the report register. A stalled report holds there while an empty input
// register still takes one more beat. Reset clears the pending count, the
// recent bytes and both valid flags; the head store needs no clearing.
// ============================================================================
module tail_delimited_word_deframer_core #(
    parameter int unsigned COUNT_WIDTH = 18
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  twdd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output twdd_pkg::out_beat_t m_data
);

    logic                in_valid_reg;
    twdd_pkg::in_beat_t  in_beat_reg;
    logic                m_valid_reg;
    twdd_pkg::out_beat_t m_data_reg;
    logic                advance;
    logic                frame_hit;
    twdd_pkg::out_beat_t report;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    twdd_frame_tracker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .beat     (in_beat_reg),
        .frame_hit(frame_hit),
        .report   (report)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= frame_hit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame_hit) begin
            m_data_reg <= report;
        end
    end

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("Input stalled without a blocked report.");

    a_held_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_beat_reg)))
        else $error("Held input beat was lost or changed.");

    a_report_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance && frame_hit))
        else $error("Report appeared without a completed tail.");

endmodule

>>> hw/rtl/twdd_frame_tracker.sv
// ============================================================================
// twdd_frame_tracker: pending byte state and frame report logic
// Holds the recent bytes, the head store and the pending counters, and forms
// the frame report for the beat that completes a tail.
// ============================================================================
module twdd_frame_tracker #(
    parameter int unsigned COUNT_WIDTH = 18
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  twdd_pkg::in_beat_t  beat,
    output logic                frame_hit,
    output twdd_pkg::out_beat_t report
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [23:0]            recent_reg;
    logic [23:0]            recent_next;
    logic [COUNT_WIDTH-1:0] pending_length_reg;
    logic [COUNT_WIDTH-1:0] pending_length_next;
    logic [1:0]             length_phase_reg;
    logic [1:0]             length_phase_next;
    logic [7:0]             head_reg [twdd_pkg::HEAD_DEPTH];

    logic [COUNT_WIDTH-1:0] count_c;
    logic [1:0]             phase_c;
    logic [COUNT_WIDTH-1:0] frame_len;
    logic [31:0]            words_wide;
    logic [15:0]            words_sat;
    logic                   trim;
    logic [7:0]             window [8];

    always_comb begin
        count_c = (pending_length_reg == COUNT_MAX) ? pending_length_reg
                                                    : pending_length_reg + 1'b1;
        phase_c = length_phase_reg + 2'd1;
        frame_hit = (count_c >= COUNT_WIDTH'(twdd_pkg::TAIL_LEN))
                    && (recent_reg == twdd_pkg::TAIL_LEAD)
                    && (beat.rx_byte == twdd_pkg::TAIL_LAST);
        recent_next = {recent_reg[15:0], beat.rx_byte};
        trim = beat.chunk_end && !frame_hit
               && (count_c >= COUNT_WIDTH'(twdd_pkg::TAIL_LEN));
        frame_len = count_c - COUNT_WIDTH'(twdd_pkg::TAIL_LEN);
        words_wide = 32'(frame_len >> 2);
        words_sat = (words_wide > 32'(twdd_pkg::WORD_SAT)) ? 16'(twdd_pkg::WORD_SAT)
                                                            : words_wide[15:0];
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            unique case (phase_c)
                2'd0: window[k] = head_reg[k];
                2'd1: window[k] = head_reg[k + 1];
                2'd2: window[k] = head_reg[k + 2];
                2'd3: window[k] = head_reg[k + 3];
                default: window[k] = head_reg[k];
            endcase
        end
    end

    always_comb begin
        if (words_wide < 32'(twdd_pkg::MIN_WORDS)) begin
            report.frame_status = twdd_pkg::FRAME_SHORT;
            report.pitch_bits   = 32'd0;
            report.yaw_bits     = 32'd0;
        end else begin
            report.frame_status = twdd_pkg::FRAME_OK;
            report.pitch_bits   = {window[3], window[2], window[1], window[0]};
            report.yaw_bits     = {window[7], window[6], window[5], window[4]};
        end
        report.word_count = words_sat;
    end

    always_comb begin
        pending_length_next = count_c;
        length_phase_next   = phase_c;
        if (frame_hit) begin
            pending_length_next = '0;
            length_phase_next   = 2'd0;
        end else if (trim) begin
            pending_length_next = COUNT_WIDTH'(twdd_pkg::KEEP_BYTES);
            length_phase_next   = 2'(twdd_pkg::KEEP_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg         <= '0;
            pending_length_reg <= '0;
            length_phase_reg   <= '0;
        end else if (step) begin
            recent_reg         <= recent_next;
            pending_length_reg <= pending_length_next;
            length_phase_reg   <= length_phase_next;
        end
    end

    // A trim keeps three bytes, so the entry at the old count lies past the
    // kept bytes and is written again before it is read.
    always_ff @(posedge aclk) begin
        if (step) begin
            if (trim) begin
                head_reg[0] <= recent_next[23:16];
                head_reg[1] <= recent_next[15:8];
                head_reg[2] <= recent_next[7:0];
            end else if (pending_length_reg < COUNT_WIDTH'(twdd_pkg::HEAD_DEPTH)) begin
                head_reg[pending_length_reg[twdd_pkg::HEAD_IDX_W-1:0]] <= beat.rx_byte;
            end
        end
    end

    a_phase_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_length_reg != COUNT_MAX) |-> (length_phase_reg == pending_length_reg[1:0]))
        else $error("Length phase disagrees with the pending count.");

    a_hit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && frame_hit) |=> (pending_length_reg == '0))
        else $error("Pending bytes remain after a frame was reported.");

    a_trim_keeps_three: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && trim) |=> (pending_length_reg == COUNT_WIDTH'(twdd_pkg::KEEP_BYTES)
                            && length_phase_reg == 2'(twdd_pkg::KEEP_BYTES)))
        else $error("Chunk end trim did not keep exactly three bytes.");

    a_short_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_hit && report.frame_status == twdd_pkg::FRAME_SHORT)
            |-> (report.pitch_bits == 32'd0 && report.yaw_bits == 32'd0))
        else $error("Short frame carries nonzero word data.");

endmodule
